[design/char_lcd_nibble_sequencer_top_macros.svh]
// Assertion helpers used by the sequencer back end.
// Each use expects a clock i_clk and an active-low reset i_rst_n in scope.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_TOP_MACROS_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset
`define LCDNS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define LCDNS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[design/lcdns_pkg.sv]
package lcdns_pkg;

    // Request opcodes
    localparam logic [1:0] OP_COMMAND = 2'd0;
    localparam logic [1:0] OP_DATA    = 2'd1;
    localparam logic [1:0] OP_CURSOR  = 2'd2;
    localparam logic [1:0] OP_STARTUP = 2'd3;

    // Transfer kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_POLL  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_COMMAND_HOLD = 2'd0;
    localparam logic [1:0] CFG_DATA_HOLD    = 2'd1;
    localparam logic [1:0] CFG_NIBBLE_GAP   = 2'd2;
    localparam logic [1:0] CFG_POST_BUSY    = 2'd3;

    localparam int HOLD_W = 20;

    // Register reset values
    localparam logic [HOLD_W-1:0] RST_COMMAND_HOLD = 20'd100000;
    localparam logic [HOLD_W-1:0] RST_DATA_HOLD    = 20'd0;
    localparam logic [HOLD_W-1:0] RST_POST_BUSY    = 20'd100;

    // Set-DDRAM-address bases per display line
    localparam logic [7:0] CURSOR_ROW0 = 8'h80;
    localparam logic [7:0] CURSOR_ROW1 = 8'hC0;

    // Start-up command bytes: 4-bit/2-line, home, entry mode, display on
    localparam int STARTUP_LEN = 4;
    localparam logic [7:0] STARTUP_CMDS [STARTUP_LEN] = '{8'h28, 8'h02, 8'h06, 8'h0F};

    // Byte job queue between front and back
    localparam int JOBQ_DEPTH = 4;
    localparam int JOBQ_PTR_W = $clog2(JOBQ_DEPTH);
    localparam int JOBQ_CNT_W = $clog2(JOBQ_DEPTH + 1);

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] byte_value;
        logic [1:0] row;
        logic [5:0] column;
    } t_req;

    typedef struct packed {
        logic [1:0]        kind;
        logic              reg_select;
        logic [3:0]        nibble;
        logic [HOLD_W-1:0] hold_ticks;
        logic              last;
    } t_res;

    // One byte to send, or a position error
    typedef struct packed {
        logic [7:0] value;
        logic       is_data;
        logic       is_last;
        logic       is_error;
    } t_job;

    typedef struct packed {
        logic              valid;
        logic [1:0]        index;
        logic [HOLD_W-1:0] data;
    } t_cfg_wr;

endpackage

[design/lcdns_front.sv]
module lcdns_front import lcdns_pkg::*; #(
    parameter int COLUMNS = 16,
    parameter int ROWS    = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    output logic full,
    input  t_req i_req,
    input  logic i_q_ready,
    output logic o_q_push,
    output t_job o_q_job
);

    localparam logic [2:0] ROW_LIMIT = 3'(ROWS);
    localparam logic [6:0] COL_LIMIT = 7'(COLUMNS);

    typedef enum logic {
        ST_ACCEPT,
        ST_STARTUP
    } t_state;

    t_state r_state;
    logic [1:0] r_step;
    logic accept;

    // Stall the requester while the start-up bytes drain or the queue is full
    assign full   = (r_state == ST_STARTUP) || !i_q_ready;
    assign accept = push && !full;

    // Classify the request into one byte job, or emit the next start-up byte
    always_comb begin
        o_q_push = 1'b0;
        o_q_job  = '0;
        if (r_state == ST_STARTUP) begin
            o_q_push         = i_q_ready;
            o_q_job.value    = STARTUP_CMDS[r_step];
            o_q_job.is_last  = (r_step == 2'(STARTUP_LEN - 1));
        end else if (accept) begin
            o_q_push        = 1'b1;
            o_q_job.is_last = 1'b1;
            unique case (i_req.op)
                OP_COMMAND: begin
                    o_q_job.value = i_req.byte_value;
                end
                OP_DATA: begin
                    o_q_job.value   = i_req.byte_value;
                    o_q_job.is_data = 1'b1;
                end
                OP_CURSOR: begin
                    if ({1'b0, i_req.row} >= ROW_LIMIT
                            || {1'b0, i_req.column} >= COL_LIMIT) begin
                        o_q_job.is_error = 1'b1;
                    end else begin
                        o_q_job.value = ((i_req.row == 2'd0) ? CURSOR_ROW0 : CURSOR_ROW1)
                                        + {2'b00, i_req.column};
                    end
                end
                OP_STARTUP: begin
                    o_q_job.value   = STARTUP_CMDS[0];
                    o_q_job.is_last = 1'b0;
                end
                default: begin
                    o_q_push = 1'b0;
                end
            endcase
        end
    end

    // Walk the remaining start-up bytes one per free queue slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACCEPT;
            r_step  <= 2'd0;
        end else begin
            unique case (r_state)
                ST_ACCEPT: begin
                    if (accept && i_req.op == OP_STARTUP) begin
                        r_state <= ST_STARTUP;
                        r_step  <= 2'd1;
                    end
                end
                ST_STARTUP: begin
                    if (i_q_ready) begin
                        if (r_step == 2'(STARTUP_LEN - 1)) begin
                            r_state <= ST_ACCEPT;
                            r_step  <= 2'd0;
                        end else begin
                            r_step <= r_step + 2'd1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_ACCEPT;
                end
            endcase
        end
    end

endmodule

[design/lcdns_jobq.sv]
module lcdns_jobq import lcdns_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_ready,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job                  r_mem [JOBQ_DEPTH];
    logic [JOBQ_PTR_W-1:0] r_wr_ptr;
    logic [JOBQ_PTR_W-1:0] r_rd_ptr;
    logic [JOBQ_CNT_W-1:0] r_count;
    logic do_push;
    logic do_pop;

    assign o_ready = (r_count != JOBQ_CNT_W'(JOBQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Store jobs
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[design/lcdns_back.sv]
`include "char_lcd_nibble_sequencer_top_macros.svh"

module lcdns_back import lcdns_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg_wr i_cfg,
    input  logic    i_job_valid,
    input  t_job    i_job,
    output logic    o_job_pop,
    output logic    empty,
    input  logic    pop,
    output t_res    o_res
);

    typedef enum logic [1:0] {
        PH_HIGH,
        PH_LOW,
        PH_POLL
    } t_phase;

    t_phase            r_phase;
    t_phase            n_phase;
    t_res              r_out;
    t_res              n_out;
    logic              r_out_valid;
    logic [HOLD_W-1:0] r_command_hold;
    logic [HOLD_W-1:0] r_data_hold;
    logic [HOLD_W-1:0] r_post_busy;
    logic              load;
    logic              done;

    assign empty     = !r_out_valid;
    assign o_res     = r_out;
    assign load      = i_job_valid && (!r_out_valid || pop);
    assign o_job_pop = load && done;

    // Build the next transfer of the current job
    always_comb begin
        n_out   = '0;
        done    = 1'b0;
        n_phase = r_phase;
        if (i_job.is_error) begin
            n_out.kind = KIND_ERROR;
            n_out.last = 1'b1;
            done       = 1'b1;
        end else begin
            unique case (r_phase)
                PH_HIGH: begin
                    n_out.kind       = KIND_WRITE;
                    n_out.reg_select = i_job.is_data;
                    n_out.nibble     = i_job.value[7:4];
                    n_out.hold_ticks = i_job.is_data ? r_data_hold : r_command_hold;
                    n_phase          = PH_LOW;
                end
                PH_LOW: begin
                    n_out.kind       = KIND_WRITE;
                    n_out.reg_select = i_job.is_data;
                    n_out.nibble     = i_job.value[3:0];
                    n_out.hold_ticks = i_job.is_data ? r_data_hold : r_command_hold;
                    n_phase          = PH_POLL;
                end
                PH_POLL: begin
                    n_out.kind       = KIND_POLL;
                    n_out.hold_ticks = r_post_busy;
                    n_out.last       = i_job.is_last;
                    done             = 1'b1;
                end
                default: begin
                    done = 1'b1;
                end
            endcase
        end
        if (done) begin
            n_phase = PH_HIGH;
        end
    end

    // Hold configuration, phase and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HIGH;
            r_out_valid    <= 1'b0;
            r_command_hold <= RST_COMMAND_HOLD;
            r_data_hold    <= RST_DATA_HOLD;
            r_post_busy    <= RST_POST_BUSY;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_COMMAND_HOLD: r_command_hold <= i_cfg.data;
                    CFG_DATA_HOLD:    r_data_hold    <= i_cfg.data;
                    // Nibble gap timing belongs to the consumer; drop it
                    CFG_NIBBLE_GAP:   ;
                    CFG_POST_BUSY:    r_post_busy    <= i_cfg.data;
                    default:          ;
                endcase
            end
            if (load) begin
                r_out       <= n_out;
                r_out_valid <= 1'b1;
                r_phase     <= n_phase;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `LCDNS_ASSERT_NOW(a_error_at_byte_start, i_job_valid && i_job.is_error, r_phase == PH_HIGH, "error job seen mid-byte")
    `LCDNS_ASSERT_NOW(a_last_not_on_write, r_out_valid && r_out.last, r_out.kind != KIND_WRITE, "last flag on a nibble write")
    `LCDNS_ASSERT_NEXT(a_poll_ends_byte, load && r_phase == PH_POLL, r_phase == PH_HIGH, "phase not restarted after poll")
    `LCDNS_ASSERT_NOW(a_pop_only_when_done, o_job_pop, load && (i_job.is_error || r_phase == PH_POLL), "job released before its last transfer")

endmodule

[design/char_lcd_nibble_sequencer_top.sv]
// Character LCD 4-bit bus sequencer.
// Requests enter through a queue-style port: present i_req with push and the
// item transfers on a clock edge where full is low. Each command, data byte
// or valid cursor move yields three transfers (high nibble, low nibble, busy
// poll); the start-up request yields twelve; a cursor move off the display
// yields one position-error result. The last result of a request has last set.
// Results leave through a queue-style port: while empty is low o_res holds
// the oldest result, and it transfers on an edge where pop is high.
// The first result of a request passes the job queue and then the output
// register. Throughput: one result per cycle while pop stays high, set by
// the single transfer builder in the back end.
// A four-entry byte queue sits between request decode and transfer output;
// when pop stays low the output register holds and the queue fills, then
// full rises. Start-up holds full high while its remaining bytes enqueue.
// Configuration writes (i_cfg_valid, always ready) set hold and wait ticks;
// write them only while no request is in flight.
// Synchronous reset on i_rst_n empties the job queue and output register and
// restores the default hold and wait values; no clearing pass is needed.
module char_lcd_nibble_sequencer_top import lcdns_pkg::*; #(
    parameter int COLUMNS = 16,
    parameter int ROWS    = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  t_req              i_req,
    output logic              empty,
    input  logic              pop,
    output t_res              o_res,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [HOLD_W-1:0] i_cfg_data
);

    t_cfg_wr cfg_wr;
    logic    q_push;
    t_job    q_wr_job;
    logic    q_ready;
    logic    q_valid;
    t_job    q_rd_job;
    logic    q_pop;

    // Registers are plain flops, so every write is taken at once
    assign o_cfg_ready  = 1'b1;
    assign cfg_wr.valid = i_cfg_valid && o_cfg_ready;
    assign cfg_wr.index = i_cfg_index;
    assign cfg_wr.data  = i_cfg_data;

    lcdns_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_req     (i_req),
        .i_q_ready (q_ready),
        .o_q_push  (q_push),
        .o_q_job   (q_wr_job)
    );

    lcdns_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_wr_job),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_rd_job)
    );

    lcdns_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg_wr),
        .i_job_valid (q_valid),
        .i_job       (q_rd_job),
        .o_job_pop   (q_pop),
        .empty       (empty),
        .pop         (pop),
        .o_res       (o_res)
    );

endmodule

[tb/char_lcd_nibble_sequencer_top_test.sv]
module char_lcd_nibble_sequencer_top_test;
    import lcdns_pkg::*;

    localparam int COLS = 16;
    localparam int LINES = 2;
    localparam logic [HOLD_W-1:0] HOLD_MAX = '1;
    localparam int STALL_MAX = 11;
    localparam int IDLE_LIMIT = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PER_PHASE = 25;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    t_req              i_req = '0;
    logic              empty;
    logic              pop = 1'b0;
    t_res              o_res;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [1:0]        i_cfg_index = '0;
    logic [HOLD_W-1:0] i_cfg_data = '0;

    // Local copy of the hold and wait registers
    logic [HOLD_W-1:0] cmd_hold;
    logic [HOLD_W-1:0] data_hold;
    logic [HOLD_W-1:0] busy_ticks;

    t_req pending_reqs[$];
    t_res expected_xfers[$];

    bit    req_fire = 1'b0;
    bit    res_fire = 1'b0;
    bit    snd_quiet = 1'b0;
    bit    rcv_quiet = 1'b0;
    int    snd_wait = 0;
    int    rcv_wait = 0;
    int    idle_cycles = 0;
    int    errors = 0;
    int    reqs_done = 0;
    int    xfers_checked = 0;
    int    settings_used = 1;
    t_res  want;
    string bad;

    char_lcd_nibble_sequencer_top #(
        .COLUMNS(COLS),
        .ROWS(LINES)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .push(push),
        .full(full),
        .i_req(i_req),
        .empty(empty),
        .pop(pop),
        .o_res(o_res),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Queue the three bus transfers of one byte
    function automatic void add_byte_xfers(input logic [7:0] value, input logic is_data,
                                           input logic is_final);
        t_res x;
        x.kind       = KIND_WRITE;
        x.reg_select = is_data;
        x.nibble     = value[7:4];
        x.hold_ticks = is_data ? data_hold : cmd_hold;
        x.last       = 1'b0;
        expected_xfers.push_back(x);
        x.nibble = value[3:0];
        expected_xfers.push_back(x);
        x.kind       = KIND_POLL;
        x.reg_select = 1'b0;
        x.nibble     = '0;
        x.hold_ticks = busy_ticks;
        x.last       = is_final;
        expected_xfers.push_back(x);
    endfunction

    // Expand one accepted request into the transfers it must produce
    function automatic void predict_request(input t_req r);
        t_res       err;
        logic [7:0] addr_cmd;
        case (r.op)
            OP_COMMAND: add_byte_xfers(r.byte_value, 1'b0, 1'b1);
            OP_DATA:    add_byte_xfers(r.byte_value, 1'b1, 1'b1);
            OP_CURSOR: begin
                if (r.row >= LINES || r.column >= COLS) begin
                    err.kind       = KIND_ERROR;
                    err.reg_select = 1'b0;
                    err.nibble     = '0;
                    err.hold_ticks = '0;
                    err.last       = 1'b1;
                    expected_xfers.push_back(err);
                end else begin
                    addr_cmd = ((r.row == 2'd0) ? CURSOR_ROW0 : CURSOR_ROW1)
                               + {2'b00, r.column};
                    add_byte_xfers(addr_cmd, 1'b0, 1'b1);
                end
            end
            default: begin
                for (int i = 0; i < STARTUP_LEN; i++)
                    add_byte_xfers(STARTUP_CMDS[i], 1'b0, i == STARTUP_LEN - 1);
            end
        endcase
    endfunction

    function automatic t_req make_req(input logic [1:0] op, input logic [7:0] value,
                                      input logic [1:0] row, input logic [5:0] column);
        t_req r;
        r.op         = op;
        r.byte_value = value;
        r.row        = row;
        r.column     = column;
        return r;
    endfunction

    // Mostly bytes and on-screen cursor moves, some off-screen moves and start-ups
    function automatic t_req random_request();
        t_req r;
        int   pick;
        r.byte_value = 8'($urandom_range(0, 255));
        r.row        = 2'($urandom_range(0, 3));
        r.column     = 6'($urandom_range(0, 63));
        pick         = $urandom_range(0, 15);
        if (pick < 5) begin
            r.op = OP_COMMAND;
        end else if (pick < 10) begin
            r.op = OP_DATA;
        end else if (pick < 14) begin
            r.op = OP_CURSOR;
            if ($urandom_range(0, 3) != 0) begin
                r.row    = 2'($urandom_range(0, LINES - 1));
                r.column = 6'($urandom_range(0, COLS - 1));
            end
        end else begin
            r.op = OP_STARTUP;
        end
        return r;
    endfunction

    // Format one transfer for reports
    function automatic string fmt_res(input t_res x);
        return $sformatf("kind=%0d rs=%0d nibble=%h hold=%0d last=%0d",
                         x.kind, x.reg_select, x.nibble, x.hold_ticks, x.last);
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [HOLD_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_COMMAND_HOLD: cmd_hold   = value;
            CFG_DATA_HOLD:    data_hold  = value;
            // Nibble gap reaches no transfer field
            CFG_NIBBLE_GAP:   ;
            CFG_POST_BUSY:    busy_ticks = value;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [HOLD_W-1:0] c_hold, input logic [HOLD_W-1:0] d_hold,
                             input logic [HOLD_W-1:0] gap, input logic [HOLD_W-1:0] busy);
        write_reg(CFG_COMMAND_HOLD, c_hold);
        write_reg(CFG_DATA_HOLD, d_hold);
        write_reg(CFG_NIBBLE_GAP, gap);
        write_reg(CFG_POST_BUSY, busy);
        settings_used++;
    endtask

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
            pending_reqs.push_back(random_request());
    endtask

    // Hold until every request is sent and every transfer seen, then settle
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || push || expected_xfers.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Request driver: one gap draw per transfer, with quiet stretches
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!push || req_fire) begin
            if (push) begin
                if ($urandom_range(0, 15) == 0) snd_quiet = !snd_quiet;
                snd_wait = snd_quiet ? 0 : $urandom_range(0, STALL_MAX);
            end
            if (snd_wait > 0) begin
                snd_wait--;
                push  <= 1'b0;
                i_req <= t_req'($urandom);
            end else if (pending_reqs.size() > 0) begin
                i_req <= pending_reqs.pop_front();
                push  <= 1'b1;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Result consumer: stall after a transfer for a random count, except in quiet stretches
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (res_fire) begin
                if ($urandom_range(0, 15) == 0) rcv_quiet = !rcv_quiet;
                rcv_wait = rcv_quiet ? 0 : $urandom_range(0, STALL_MAX);
            end
            if (rcv_wait > 0) begin
                rcv_wait--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Monitor: predict on request transfer, check on result transfer
    always @(posedge i_clk) begin
        req_fire = i_rst_n && push && !full;
        res_fire = i_rst_n && pop && !empty;
        if (req_fire) begin
            predict_request(i_req);
            reqs_done++;
        end
        if (res_fire) begin
            if (expected_xfers.size() == 0) begin
                errors++;
                $display("%0t: unexpected transfer: expected none, got %s",
                         $time, fmt_res(o_res));
            end else begin
                want = expected_xfers.pop_front();
                bad  = "";
                if (o_res.kind !== want.kind) bad = {bad, " kind"};
                if (o_res.reg_select !== want.reg_select) bad = {bad, " reg_select"};
                if (o_res.nibble !== want.nibble) bad = {bad, " nibble"};
                if (o_res.hold_ticks !== want.hold_ticks) bad = {bad, " hold_ticks"};
                if (o_res.last !== want.last) bad = {bad, " last"};
                if (bad != "") begin
                    errors++;
                    $display("%0t: mismatch in%s: expected %s, got %s",
                             $time, bad, fmt_res(want), fmt_res(o_res));
                end
                xfers_checked++;
            end
        end
        // Watchdog on cycles without any transfer
        if (!i_rst_n || req_fire || res_fire || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: timeout, no transfer for %0d cycles, %0d transfers outstanding",
                         $time, idle_cycles, expected_xfers.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        cmd_hold   = RST_COMMAND_HOLD;
        data_hold  = RST_DATA_HOLD;
        busy_ticks = RST_POST_BUSY;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: byte extremes, every op, cursor corners and off-screen moves
        pending_reqs.push_back(make_req(OP_COMMAND, 8'h00, 2'd3, 6'd63));
        pending_reqs.push_back(make_req(OP_COMMAND, 8'hFF, 2'd0, 6'd0));
        pending_reqs.push_back(make_req(OP_DATA, 8'h00, 2'd2, 6'd40));
        pending_reqs.push_back(make_req(OP_DATA, 8'hFF, 2'd1, 6'd21));
        pending_reqs.push_back(make_req(OP_DATA, 8'hA5, 2'd0, 6'd0));
        pending_reqs.push_back(make_req(OP_COMMAND, 8'h5A, 2'd0, 6'd0));
        pending_reqs.push_back(make_req(OP_CURSOR, 8'hFF, 2'd0, 6'd0));
        pending_reqs.push_back(make_req(OP_CURSOR, 8'h00, 2'd0, 6'(COLS - 1)));
        pending_reqs.push_back(make_req(OP_CURSOR, 8'h3C, 2'd1, 6'd0));
        pending_reqs.push_back(make_req(OP_CURSOR, 8'hC3, 2'd1, 6'(COLS - 1)));
        pending_reqs.push_back(make_req(OP_CURSOR, 8'h00, 2'd0, 6'(COLS)));
        pending_reqs.push_back(make_req(OP_CURSOR, 8'h00, 2'd1, 6'd63));
        pending_reqs.push_back(make_req(OP_CURSOR, 8'h00, 2'd2, 6'd0));
        pending_reqs.push_back(make_req(OP_CURSOR, 8'h00, 2'd3, 6'd63));
        pending_reqs.push_back(make_req(OP_CURSOR, 8'h00, 2'd2, 6'd5));
        pending_reqs.push_back(make_req(OP_STARTUP, 8'hFF, 2'd3, 6'd63));
        pending_reqs.push_back(make_req(OP_STARTUP, 8'h00, 2'd0, 6'd0));
        pending_reqs.push_back(make_req(OP_DATA, 8'h7E, 2'd0, 6'd0));
        wait_drained();

        // Random traffic under several register settings, draining between them
        write_all('0, '0, '0, '0);
        queue_random(RANDOM_PER_PHASE);
        wait_drained();
        write_all(HOLD_MAX, HOLD_MAX, HOLD_MAX, HOLD_MAX);
        queue_random(RANDOM_PER_PHASE);
        wait_drained();
        write_all(HOLD_W'($urandom_range(0, HOLD_MAX)), HOLD_W'($urandom_range(0, HOLD_MAX)),
                  HOLD_W'($urandom_range(0, HOLD_MAX)), HOLD_W'($urandom_range(0, HOLD_MAX)));
        queue_random(RANDOM_PER_PHASE);
        wait_drained();
        write_all(HOLD_MAX, '0, HOLD_W'($urandom_range(0, HOLD_MAX)), 20'd1);
        queue_random(RANDOM_PER_PHASE);
        wait_drained();

        $display("Sent %0d requests covering every op, cursor corners and off-screen moves",
                 reqs_done);
        $display("under %0d register settings; checked %0d bus transfers, %0d mismatches.",
                 settings_used, xfers_checked, errors);
        if (errors == 0 && expected_xfers.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
